/* rtl/mktm_pkg.sv */
package mktm_pkg;

  localparam int unsigned CH_W      = 6;
  localparam int unsigned TIME_W    = 20;
  localparam int unsigned ID_W      = 17;
  localparam int unsigned DIST_W    = 48;
  localparam int unsigned RANK_W    = 4;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned NC_W      = 5;
  localparam int unsigned MASK_W    = 60;
  localparam int unsigned SUM_W     = 27;
  localparam int unsigned DIFF_W    = TIME_W + 2;
  localparam int unsigned SQ_W      = 2 * DIFF_W;
  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 72;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [NC_W-1:0]   NC_RESET   = 5'd16;
  localparam logic [MASK_W-1:0] MASK_RESET = 60'd299490475336009760;

  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAD_MASK       = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_EVENT    = 2'd0,
    OP_TEMPLATE = 2'd1,
    OP_REPORT   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_SQUARE,
    ST_ACCUM,
    ST_INS_CHECK,
    ST_INS_SHIFT,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic accept_ev;
    logic accept_tp;
    logic sum_clear;
    logic sum_run;
    logic div_start;
    logic div_step;
    logic ev_finish;
    logic tp_square;
    logic tp_accum;
    logic ins_check;
    logic ins_shift;
    logic rep_start;
    logic rep_emit;
  } cmd_t;

  typedef struct packed {
    logic sum_done;
    logic div_done;
    logic tp_last;
    logic id_ok;
    logic ins_take;
    logic shift_done;
    logic rep_empty;
    logic rep_final;
    logic out_free;
  } sts_t;

endpackage

/* rtl/masked_knn_template_matcher.sv */
// Channel  Direction  Handshake              Contents
// s_axis   in         tvalid/tready          tuser operation, tdata samples, tlast last_channel
// m_axis   out        tvalid/tready          tdata rank/match_id/distance, tlast final_res
// cfg      in         cfg_we_i, no wait      index 0 neighbor_count, 1 bad_channel_mask
//
// Event sample without last: written to the sample store, input stays ready. Event last
// sample: a sweep of the sample memory (one read a cycle), then a 27-step bit-serial divide.
// Template sample: read, square and accumulate; a last sample whose id is below
// TEMPLATE_LIMIT adds a check and an insertion, one list entry moved per cycle.
// Report: one result per cycle while m_axis_tready is high; the output register
// lets the final result wait while the next item is taken.
// Reset is asynchronous, active low, and needs no clearing pass.
module masked_knn_template_matcher #(
  parameter int unsigned CHANNEL_COUNT  = 60,
  parameter int unsigned LIST_DEPTH     = 16,
  parameter int unsigned TEMPLATE_LIMIT = 131072
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mktm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mktm_pkg::MASK_W-1:0]       cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // channel[5:0], time_value[25:6], template_id[42:26], zero[47:43]
  input  logic [mktm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // operation[1:0]
  input  logic [mktm_pkg::OP_W-1:0]         s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // rank[3:0], match_id[20:4], distance[68:21], zero[71:69]
  output logic [mktm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast
);

  mktm_pkg::cmd_t cmd;
  mktm_pkg::sts_t sts;

  mktm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  mktm_dp #(
    .CHANNEL_COUNT  (CHANNEL_COUNT),
    .LIST_DEPTH     (LIST_DEPTH),
    .TEMPLATE_LIMIT (TEMPLATE_LIMIT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

/* rtl/mktm_ctrl.sv */
module mktm_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  input  logic [mktm_pkg::OP_W-1:0] s_axis_tuser,
  input  logic                      s_axis_tlast,
  output logic                      s_axis_tready,
  input  mktm_pkg::sts_t            sts_i,
  output mktm_pkg::cmd_t            cmd_o
);

  mktm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mktm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mktm_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            mktm_pkg::OP_EVENT: begin
              if (s_axis_tlast) state_d = mktm_pkg::ST_SUM;
            end
            mktm_pkg::OP_TEMPLATE: state_d = mktm_pkg::ST_SQUARE;
            mktm_pkg::OP_REPORT: begin
              if (!sts_i.rep_empty) state_d = mktm_pkg::ST_REPORT;
            end
            default: state_d = mktm_pkg::ST_IDLE;
          endcase
        end
      end
      mktm_pkg::ST_SUM: begin
        if (sts_i.sum_done) state_d = mktm_pkg::ST_DIV;
      end
      mktm_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = mktm_pkg::ST_IDLE;
      end
      mktm_pkg::ST_SQUARE: state_d = mktm_pkg::ST_ACCUM;
      mktm_pkg::ST_ACCUM: begin
        state_d = (sts_i.tp_last && sts_i.id_ok) ? mktm_pkg::ST_INS_CHECK : mktm_pkg::ST_IDLE;
      end
      mktm_pkg::ST_INS_CHECK: begin
        state_d = sts_i.ins_take ? mktm_pkg::ST_INS_SHIFT : mktm_pkg::ST_IDLE;
      end
      mktm_pkg::ST_INS_SHIFT: begin
        if (sts_i.shift_done) state_d = mktm_pkg::ST_IDLE;
      end
      mktm_pkg::ST_REPORT: begin
        if (sts_i.out_free && sts_i.rep_final) state_d = mktm_pkg::ST_IDLE;
      end
      default: state_d = mktm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      mktm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            mktm_pkg::OP_EVENT: begin
              cmd_o.accept_ev = 1'b1;
              cmd_o.sum_clear = s_axis_tlast;
            end
            mktm_pkg::OP_TEMPLATE: cmd_o.accept_tp = 1'b1;
            mktm_pkg::OP_REPORT:   cmd_o.rep_start = !sts_i.rep_empty;
            default: cmd_o = '0;
          endcase
        end
      end
      mktm_pkg::ST_SUM: begin
        cmd_o.sum_run   = 1'b1;
        cmd_o.div_start = sts_i.sum_done;
      end
      mktm_pkg::ST_DIV: begin
        cmd_o.ev_finish = sts_i.div_done;
        cmd_o.div_step  = !sts_i.div_done;
      end
      mktm_pkg::ST_SQUARE:    cmd_o.tp_square = 1'b1;
      mktm_pkg::ST_ACCUM:     cmd_o.tp_accum  = 1'b1;
      mktm_pkg::ST_INS_CHECK: cmd_o.ins_check = 1'b1;
      mktm_pkg::ST_INS_SHIFT: cmd_o.ins_shift = 1'b1;
      mktm_pkg::ST_REPORT:    cmd_o.rep_emit  = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* rtl/mktm_dp.sv */
module mktm_dp #(
  parameter int unsigned CHANNEL_COUNT  = 60,
  parameter int unsigned LIST_DEPTH     = 16,
  parameter int unsigned TEMPLATE_LIMIT = 131072
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mktm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mktm_pkg::MASK_W-1:0]       cfg_wdata_i,
  input  logic [mktm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mktm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                              m_axis_tlast,
  input  mktm_pkg::cmd_t                    cmd_i,
  output mktm_pkg::sts_t                    sts_o
);

  localparam int unsigned AW  = $clog2(CHANNEL_COUNT);
  localparam int unsigned IXW = $clog2(CHANNEL_COUNT + 1);
  localparam int unsigned GW  = $clog2(CHANNEL_COUNT + 1);
  localparam int unsigned PW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned FW  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CW  = $clog2(mktm_pkg::SUM_W + 1);

  localparam int unsigned CH_W   = mktm_pkg::CH_W;
  localparam int unsigned TIME_W = mktm_pkg::TIME_W;
  localparam int unsigned ID_W   = mktm_pkg::ID_W;
  localparam int unsigned DIST_W = mktm_pkg::DIST_W;
  localparam int unsigned SUM_W  = mktm_pkg::SUM_W;
  localparam int unsigned DIFF_W = mktm_pkg::DIFF_W;
  localparam int unsigned SQ_W   = mktm_pkg::SQ_W;
  localparam int unsigned MASK_W = mktm_pkg::MASK_W;

  logic [CH_W-1:0]          in_ch;
  logic signed [TIME_W-1:0] in_time;
  logic [ID_W-1:0]          in_id;

  assign in_ch   = s_axis_tdata[CH_W-1:0];
  assign in_time = s_axis_tdata[CH_W+TIME_W-1:CH_W];
  assign in_id   = s_axis_tdata[CH_W+TIME_W+ID_W-1:CH_W+TIME_W];

  logic [mktm_pkg::NC_W-1:0] nc_q;
  logic [MASK_W-1:0]         mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nc_q   <= mktm_pkg::NC_RESET;
      mask_q <= mktm_pkg::MASK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mktm_pkg::REG_NEIGHBOR_COUNT: nc_q   <= cfg_wdata_i[mktm_pkg::NC_W-1:0];
        mktm_pkg::REG_BAD_MASK:       mask_q <= cfg_wdata_i;
        default: nc_q <= nc_q;
      endcase
    end
  end

  function automatic logic chan_good(input logic [CH_W:0] c, input logic [MASK_W-1:0] m);
    logic in_range;
    in_range = int'(c) < CHANNEL_COUNT;
    return in_range && ((int'(c) >= MASK_W) || !m[c[CH_W-1:0]]);
  endfunction

  // event sample store
  logic signed [TIME_W-1:0] ev_mem [CHANNEL_COUNT];
  logic signed [TIME_W-1:0] rd_q;
  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [IXW-1:0]           idx_q;

  assign mem_we    = cmd_i.accept_ev && (int'(in_ch) < CHANNEL_COUNT);
  assign mem_re    = cmd_i.accept_tp || (cmd_i.sum_run && (int'(idx_q) < CHANNEL_COUNT));
  assign mem_raddr = cmd_i.sum_run ? idx_q[AW-1:0] : in_ch[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) ev_mem[in_ch[AW-1:0]] <= in_time;
    if (mem_re) rd_q <= ev_mem[mem_raddr];
  end

  // captured item
  logic signed [TIME_W-1:0] t_q;
  logic [ID_W-1:0]          id_q;
  logic                     last_q;
  logic                     tgood_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_tp) begin
      t_q     <= in_time;
      id_q    <= in_id;
      last_q  <= s_axis_tlast;
      tgood_q <= chan_good({1'b0, in_ch}, mask_q);
    end
  end

  // mean: sweep then restoring divide
  logic                    tag_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [GW-1:0]           good_q;
  logic [GW-1:0]           rem_q;
  logic [SUM_W-1:0]        quo_q;
  logic                    neg_q;
  logic [CW-1:0]           cnt_q;
  logic signed [TIME_W-1:0] mean_q;
  logic [GW:0]             div_sh;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        quo_signed;

  assign sum_mag    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign div_sh     = {rem_q, quo_q[SUM_W-1]};
  assign quo_signed = neg_q ? SUM_W'(-quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      tag_q  <= 1'b0;
      sum_q  <= '0;
      good_q <= '0;
      cnt_q  <= '0;
      mean_q <= '0;
    end else begin
      if (cmd_i.sum_clear) begin
        idx_q  <= '0;
        tag_q  <= 1'b0;
        sum_q  <= '0;
        good_q <= '0;
      end else if (cmd_i.sum_run) begin
        if (int'(idx_q) < CHANNEL_COUNT) begin
          tag_q <= chan_good((CH_W+1)'(idx_q), mask_q);
          idx_q <= idx_q + IXW'(1);
        end else begin
          tag_q <= 1'b0;
        end
        if (tag_q) begin
          sum_q  <= sum_q + SUM_W'(rd_q);
          good_q <= good_q + GW'(1);
        end
      end
      if (cmd_i.div_start) begin
        cnt_q <= CW'(SUM_W);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.ev_finish) begin
        mean_q <= (good_q == '0) ? '0 : TIME_W'(quo_signed);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= sum_mag;
      neg_q <= sum_q[SUM_W-1];
    end else if (cmd_i.div_step) begin
      if (div_sh >= {1'b0, good_q}) begin
        rem_q <= GW'(div_sh - {1'b0, good_q});
        quo_q <= {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_q <= div_sh[GW-1:0];
        quo_q <= {quo_q[SUM_W-2:0], 1'b0};
      end
    end
  end

  // distance
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [SQ_W-1:0]          sq_q;
  logic [DIST_W-1:0]        acc_q;
  logic [DIST_W:0]          acc_sum;
  logic [DIST_W-1:0]        acc_nxt;
  logic [DIST_W-1:0]        newd_q;

  assign diff    = DIFF_W'(rd_q) - DIFF_W'(mean_q) - DIFF_W'(t_q);
  assign mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign acc_sum = {1'b0, acc_q} + (DIST_W+1)'(sq_q);
  assign acc_nxt = !tgood_q ? acc_q : (acc_sum[DIST_W] ? '1 : acc_sum[DIST_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.tp_square) sq_q <= mag * mag;
    if (cmd_i.tp_accum && last_q) newd_q <= acc_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.ev_finish) begin
      acc_q <= '0;
    end else if (cmd_i.tp_accum) begin
      acc_q <= last_q ? '0 : acc_nxt;
    end
  end

  // best list
  logic [DIST_W-1:0] dist_q [LIST_DEPTH];
  logic [ID_W-1:0]   lid_q  [LIST_DEPTH];
  logic [FW-1:0]     fill_q;
  logic [PW-1:0]     pos_q;
  logic [PW-1:0]     r_q;
  logic [FW-1:0]     n_q;
  logic [FW-1:0]     kept;
  logic [FW-1:0]     n_cur;
  logic [PW-1:0]     lr_idx;
  logic [DIST_W-1:0] lr_dist;
  logic              shift_gt;
  logic              has_room;

  always_comb begin
    if (nc_q == '0) begin
      kept = FW'(1);
    end else if (int'(nc_q) > LIST_DEPTH) begin
      kept = FW'(LIST_DEPTH);
    end else begin
      kept = FW'(nc_q);
    end
    n_cur = (fill_q < kept) ? fill_q : kept;
    if (cmd_i.ins_check) begin
      lr_idx = PW'(kept - FW'(1));
    end else if (cmd_i.ins_shift) begin
      lr_idx = pos_q - PW'(1);
    end else begin
      lr_idx = r_q;
    end
  end

  assign lr_dist  = dist_q[lr_idx];
  assign has_room = n_cur < kept;
  assign shift_gt = (pos_q != '0) && (lr_dist > newd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.ev_finish) begin
      fill_q <= '0;
    end else if (cmd_i.ins_check) begin
      fill_q <= has_room ? n_cur + FW'(1) : n_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_check) begin
      pos_q <= has_room ? PW'(n_cur) : PW'(kept - FW'(1));
    end else if (cmd_i.ins_shift) begin
      if (shift_gt) begin
        dist_q[pos_q] <= lr_dist;
        lid_q[pos_q]  <= lid_q[lr_idx];
        pos_q         <= pos_q - PW'(1);
      end else begin
        dist_q[pos_q] <= newd_q;
        lid_q[pos_q]  <= id_q;
      end
    end
    if (cmd_i.rep_start) begin
      r_q <= '0;
      n_q <= n_cur;
    end else if (cmd_i.rep_emit) begin
      r_q <= r_q + PW'(1);
    end
  end

  // output register
  logic                              out_valid_q;
  logic [mktm_pkg::RANK_W-1:0]       out_rank_q;
  logic [ID_W-1:0]                   out_id_q;
  logic [DIST_W-1:0]                 out_dist_q;
  logic                              out_last_q;
  logic                              rep_final;

  assign rep_final = ((FW+1)'(r_q) + (FW+1)'(1)) == (FW+1)'(n_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rep_emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rep_emit) begin
      out_rank_q <= mktm_pkg::RANK_W'(r_q);
      out_id_q   <= lid_q[lr_idx];
      out_dist_q <= lr_dist;
      out_last_q <= rep_final;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {3'b000, out_dist_q, out_id_q, out_rank_q};

  always_comb begin
    sts_o            = '0;
    sts_o.sum_done   = (int'(idx_q) == CHANNEL_COUNT) && !tag_q;
    sts_o.div_done   = (cnt_q == '0);
    sts_o.tp_last    = last_q;
    sts_o.id_ok      = {15'd0, id_q} < 32'(TEMPLATE_LIMIT);
    sts_o.ins_take   = has_room || (newd_q < lr_dist);
    sts_o.shift_done = !shift_gt;
    sts_o.rep_empty  = (n_cur == '0);
    sts_o.rep_final  = rep_final;
    sts_o.out_free   = !out_valid_q || m_axis_tready;
  end

endmodule

/* rtl/mktm_checker.sv */
module mktm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [mktm_pkg::OP_W-1:0]      s_axis_tuser,
  input logic                           s_axis_tlast,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mktm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_report_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken in the middle of a report");

  a_event_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == mktm_pkg::OP_EVENT) && !s_axis_tlast
      |=> s_axis_tready)
    else $error("event sample did not complete in one cycle");

  a_template_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == mktm_pkg::OP_TEMPLATE)
      |=> !s_axis_tready)
    else $error("template sample did not occupy the datapath");

endmodule

bind masked_knn_template_matcher mktm_checker u_mktm_checker (.*);

/* sim/masked_knn_template_matcher_tb.sv */
module masked_knn_template_matcher_tb;

  localparam int unsigned OP_W      = mktm_pkg::OP_W;
  localparam int unsigned CH_W      = mktm_pkg::CH_W;
  localparam int unsigned TIME_W    = mktm_pkg::TIME_W;
  localparam int unsigned ID_W      = mktm_pkg::ID_W;
  localparam int unsigned DIST_W    = mktm_pkg::DIST_W;
  localparam int unsigned RANK_W    = mktm_pkg::RANK_W;
  localparam int unsigned NC_W      = mktm_pkg::NC_W;
  localparam int unsigned MASK_W    = mktm_pkg::MASK_W;
  localparam int unsigned CFG_IDX_W = mktm_pkg::CFG_IDX_W;

  localparam int unsigned NCH = 60;
  localparam int unsigned DEPTH = 16;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [DIST_W-1:0] DIST_SAT = '1;
  localparam int unsigned SETTLE_CYCLES = 120;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   match_id;
    logic [DIST_W-1:0] distance;
    logic              final_res;
  } match_t;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [CH_W-1:0]          ch;
    logic signed [TIME_W-1:0] tval;
    logic [ID_W-1:0]          id;
    logic                     last;
    bit                       typed;
    int                       n_typed;
    match_t                   typed_res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASK_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [mktm_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [mktm_pkg::M_TDATA_W-1:0] m_tdata;
  logic m_tlast;

  masked_knn_template_matcher u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [NC_W-1:0]          kept_cfg;
  logic [MASK_W-1:0]        bad_mask;
  logic signed [TIME_W-1:0] ev_times [NCH];
  longint                   ev_mean;
  logic [DIST_W-1:0]        dist_acc;
  logic [DIST_W-1:0]        best_dist [DEPTH];
  logic [ID_W-1:0]          best_id [DEPTH];
  int unsigned              fill;

  match_t expected_matches [$];
  match_t new_matches [$];
  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit pressure_on = 1'b0;
  bit pressure_done = 1'b0;
  int hold_cnt = 0;

  function automatic bit chan_good(int unsigned c);
    return c < NCH && !bad_mask[c];
  endfunction

  function automatic int unsigned kept_slots();
    if (kept_cfg == 0) return 1;
    if (kept_cfg > DEPTH) return DEPTH;
    return kept_cfg;
  endfunction

  function automatic void insert_match(logic [DIST_W-1:0] d, logic [ID_W-1:0] id);
    int unsigned k, n, pos;
    k = kept_slots();
    n = fill < k ? fill : k;
    if (n < k) begin
      pos = n;
      n++;
    end else if (d < best_dist[k-1]) begin
      pos = k - 1;
    end else begin
      fill = n;
      return;
    end
    while (pos > 0 && best_dist[pos-1] > d) begin
      best_dist[pos] = best_dist[pos-1];
      best_id[pos] = best_id[pos-1];
      pos--;
    end
    best_dist[pos] = d;
    best_id[pos] = id;
    fill = n;
  endfunction

  // advance the predictor by one accepted transaction, results go to new_matches
  function automatic void predict_matches(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                                          logic signed [TIME_W-1:0] tv, logic [ID_W-1:0] id,
                                          logic last);
    longint sum, good, diff;
    longint unsigned mag, acc;
    int unsigned k, n;
    match_t m;
    new_matches.delete();
    if (op == mktm_pkg::OP_EVENT) begin
      if (ch < NCH) ev_times[ch] = tv;
      if (last) begin
        sum = 0;
        good = 0;
        for (int c = 0; c < NCH; c++) begin
          if (chan_good(c)) begin
            sum += longint'(ev_times[c]);
            good++;
          end
        end
        ev_mean = good != 0 ? sum / good : 0;
        fill = 0;
        dist_acc = '0;
      end
    end else if (op == mktm_pkg::OP_TEMPLATE) begin
      if (chan_good(ch)) begin
        diff = longint'(ev_times[ch]) - ev_mean - longint'(tv);
        mag = diff < 0 ? longint'(-diff) : diff;
        acc = longint'(dist_acc) + mag * mag;
        dist_acc = acc > longint'(DIST_SAT) ? DIST_SAT : acc[DIST_W-1:0];
      end
      if (last) begin
        insert_match(dist_acc, id);
        dist_acc = '0;
      end
    end else if (op == mktm_pkg::OP_REPORT) begin
      k = kept_slots();
      n = fill < k ? fill : k;
      for (int unsigned r = 0; r < n; r++) begin
        m.rank = r[RANK_W-1:0];
        m.match_id = best_id[r];
        m.distance = best_dist[r];
        m.final_res = (r + 1 == n);
        new_matches.push_back(m);
      end
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MASK_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == mktm_pkg::REG_NEIGHBOR_COUNT) kept_cfg = val[NC_W-1:0];
    else bad_mask = val;
  endtask

  // offer one transaction, hold until accepted; typed rows replace the prediction
  task automatic send_item(logic [OP_W-1:0] op, logic [CH_W-1:0] ch,
                           logic signed [TIME_W-1:0] tv, logic [ID_W-1:0] id,
                           logic last, bit typed = 0, int n_typed = 0,
                           match_t typed_res = '0);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {5'b0, id, tv, ch};
    s_tlast <= last;
    do @(posedge clk_i); while (!s_tready);
    predict_matches(op, ch, tv, id, last);
    if (typed) begin
      for (int i = 0; i < n_typed; i++) expected_matches.push_back(typed_res);
    end else begin
      foreach (new_matches[i]) expected_matches.push_back(new_matches[i]);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_matches.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [TIME_W-1:0] pick_time();
    if ($urandom_range(1)) return TIME_W'($urandom);
    return TIME_W'($signed($urandom_range(8)) - 4);
  endfunction

  task automatic random_traffic(int target);
    int sent, r, n;
    logic [ID_W-1:0] id;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(99);
      if (r < 12) begin
        n = $urandom_range(6, 1);
        for (int i = 0; i < n; i++)
          send_item(mktm_pkg::OP_EVENT, CH_W'($urandom_range(63)), pick_time(),
                    ID_W'($urandom), i == n - 1);
        sent += n;
      end else if (r < 80) begin
        n = $urandom_range(8, 1);
        id = ID_W'($urandom);
        for (int i = 0; i < n; i++)
          send_item(mktm_pkg::OP_TEMPLATE, CH_W'($urandom_range(63)), pick_time(), id,
                    i == n - 1 && $urandom_range(19) != 0);
        sent += n;
      end else if (r < 95) begin
        send_item(mktm_pkg::OP_REPORT, CH_W'($urandom), TIME_W'($urandom), ID_W'($urandom),
                  1'($urandom_range(1)));
        sent++;
      end else begin
        send_item(OP_UNUSED, CH_W'($urandom), TIME_W'($urandom), ID_W'($urandom),
                  1'($urandom_range(1)));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (pressure_on && !pressure_done) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= 400) pressure_done <= 1'b1;
    end else begin
      m_tready <= $urandom_range(99) >= rx_stall_pct;
    end
  end

  always @(posedge clk_i) begin
    match_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.rank = m_tdata[3:0];
      got.match_id = m_tdata[20:4];
      got.distance = m_tdata[68:21];
      got.final_res = m_tlast;
      if (expected_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected match %p", got);
      end else begin
        want = expected_matches.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    stim_row_t rows [$];
    logic [NC_W-1:0] phase_nc [6] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd3, 5'd8};
    int phase_tx [6] = '{0, 88, 0, 8, 0, 0};
    int phase_rx [6] = '{0, 0, 88, 8, 0, 0};
    logic [MASK_W-1:0] mask;

    kept_cfg = mktm_pkg::NC_RESET;
    bad_mask = mktm_pkg::MASK_RESET;
    ev_mean = 0;
    dist_acc = '0;
    fill = 0;
    foreach (ev_times[i]) ev_times[i] = '0;
    foreach (best_dist[i]) begin
      best_dist[i] = '0;
      best_id[i] = '0;
    end

    rows = '{
      '{mktm_pkg::OP_REPORT,   6'd0,  20'sd0,      17'd0,      1'b0, 1, 0, '0},
      '{mktm_pkg::OP_TEMPLATE, 6'd0,  20'sh80000,  17'd131071, 1'b1, 0, 0, '0},
      '{mktm_pkg::OP_REPORT,   6'd0,  20'sd0,      17'd0,      1'b0, 1, 1,
        '{4'd0, 17'd131071, 48'd274877906944, 1'b1}},
      '{mktm_pkg::OP_TEMPLATE, 6'd5,  20'sd524287, 17'd0,      1'b1, 0, 0, '0},
      '{mktm_pkg::OP_TEMPLATE, 6'd63, 20'sd100,    17'd1,      1'b1, 0, 0, '0},
      '{mktm_pkg::OP_TEMPLATE, 6'd59, 20'sd16,     17'd2,      1'b0, 0, 0, '0},
      '{mktm_pkg::OP_TEMPLATE, 6'd59, -20'sd16,    17'd3,      1'b1, 0, 0, '0},
      '{OP_UNUSED,             6'd63, -20'sd1,     17'd131071, 1'b1, 1, 0, '0},
      '{mktm_pkg::OP_REPORT,   6'd0,  20'sd0,      17'd0,      1'b1, 0, 0, '0},
      '{mktm_pkg::OP_EVENT,    6'd59, 20'sd524287, 17'd0,      1'b0, 0, 0, '0},
      '{mktm_pkg::OP_EVENT,    6'd59, 20'sh80000,  17'd0,      1'b0, 0, 0, '0},
      '{mktm_pkg::OP_EVENT,    6'd63, 20'sd5,      17'd0,      1'b1, 0, 0, '0},
      '{mktm_pkg::OP_REPORT,   6'd0,  20'sd0,      17'd0,      1'b0, 1, 0, '0},
      '{mktm_pkg::OP_TEMPLATE, 6'd0,  20'sd0,      17'd5,      1'b1, 0, 0, '0},
      '{mktm_pkg::OP_REPORT,   6'd0,  20'sd0,      17'd0,      1'b0, 0, 0, '0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // write every event channel once so no stored sample is ever undefined
    for (int c = 0; c < NCH; c++)
      send_item(mktm_pkg::OP_EVENT, CH_W'(c), 20'sd0, 17'd0, c == NCH - 1);

    foreach (rows[i])
      send_item(rows[i].op, rows[i].ch, rows[i].tval, rows[i].id, rows[i].last,
                rows[i].typed, rows[i].n_typed, rows[i].typed_res);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: mask = '1;
        1, 5: mask = '0;
        3: mask = mktm_pkg::MASK_RESET;
        default: mask = MASK_W'({$urandom, $urandom});
      endcase
      write_reg(mktm_pkg::REG_NEIGHBOR_COUNT, phase_nc[p]);
      write_reg(mktm_pkg::REG_BAD_MASK, mask);
      tx_idle_pct = phase_tx[p];
      rx_stall_pct = phase_rx[p];
      if (p == 3) begin
        pressure_on = 1'b1;
        repeat (3) send_item(mktm_pkg::OP_REPORT, 6'd0, 20'sd0, 17'd0, 1'b0);
      end
      random_traffic(22);
    end

    drain();
    if (mismatches == 0 && expected_matches.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mktm_pkg.sv
rtl/mktm_ctrl.sv
rtl/mktm_dp.sv
rtl/masked_knn_template_matcher.sv
rtl/mktm_checker.sv
sim/masked_knn_template_matcher_tb.sv
